// ===== sv/spi_pkg.sv =====
// package: shared types, constants and command/status structs for the segment-polygon unit
`default_nettype none
package spi_pkg;
   localparam int COORD_BITS = 16;            // vertex and segment coordinate width
   localparam int SQ_BITS = 34;               // squared distance width for 16-bit coords
   localparam int ROOT_BITS = 25;             // floor(sqrt(s<<16)) width
   localparam int ROOT_STEPS = 25;            // one root bit per step
   localparam logic [0:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [0:0] CSR_EPS_TOLERANCE = 1'b1;
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_EDGE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN_START, ST_LEN_WAIT, ST_V_READ, ST_V_START, ST_V_WAIT,
      ST_V_CHECK, ST_E_READ0, ST_E_READ1, ST_E_MUL, ST_E_SUM, ST_E_CHECK, ST_DONE
   } state_type;

   typedef struct packed {
      logic load_query;   // capture segment
      logic write_vertex; // store vertex
      logic len_start;    // start the segment length root
      logic v_read;       // read vertex k
      logic v_start;      // start the two vertex roots
      logic e_read0;      // read vertex k as edge start
      logic e_read1;      // read vertex j as edge end
      logic e_mul;        // multiply stage
      logic e_sum;        // sum stage
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic v_on_seg;
      logic e_cross;
   } status_type;
endpackage
`default_nettype wire

// ===== sv/spi_root.sv =====
// iterative square root: floor(sqrt(s<<16)), one result bit per cycle
`default_nettype none
module spi_root
   import spi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SQ_BITS-1:0]   radicand,
   output logic                      done,
   output logic [ROOT_BITS-1:0]      root
);
   localparam int RAD_BITS = 2 * ROOT_BITS;
   logic [RAD_BITS-1:0] rad_ff, rad_in;
   logic [ROOT_BITS+1:0] rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [ROOT_BITS+1:0] rem_sh, trial;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rem_sh = {rem_ff[ROOT_BITS-1:0], rad_ff[RAD_BITS-1 -: 2]};
      trial = {root_ff, 2'b01};
      if (start) begin
         rad_in = {radicand, 16'd0};
         rem_in = '0;
         root_in = '0;
         cnt_in = 5'(ROOT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign done = ~busy_ff & ~start;
   assign root = root_ff;
endmodule
`default_nettype wire

// ===== sv/spi_datapath.sv =====
// datapath: vertex memory, segment registers, distance and edge arithmetic
`default_nettype none
module spi_datapath
   import spi_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int IDX_BITS = 4
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [IDX_BITS-1:0]   rd_k,
   input  wire logic [IDX_BITS-1:0]   rd_j,
   input  wire logic [IDX_BITS-1:0]   wr_idx,
   input  wire logic [15:0]           eps,
   input  wire logic signed [15:0]    in_px,
   input  wire logic signed [15:0]    in_py,
   input  wire logic signed [15:0]    in_qx,
   input  wire logic signed [15:0]    in_qy,
   output status_type                 status
);
   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rx_ff, ry_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, qx_ff, qy_ff;
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff;
   logic [IDX_BITS-1:0] rd_addr;
   logic [ROOT_BITS-1:0] len_ff, d1_ff;
   logic [SQ_BITS-1:0] sq_a, sq_b;
   logic signed [COORD_BITS:0] ax, ay, bx, by;
   logic root_done_a, root_done_b;
   logic [ROOT_BITS-1:0] root_a, root_b;
   logic second_ff;
   // edge products
   logic signed [COORD_BITS:0] lx, ly, ex, ey, wx, wy;
   logic signed [2*COORD_BITS+1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [2*COORD_BITS+2:0] den_ff, na_ff, nb_ff;
   logic [ROOT_BITS:0] sum, lim_hi, sum_eps;
   logic in_a, in_b;

   always_ff @(posedge clock) begin
      if (cmd.write_vertex) begin
         mem_x[wr_idx] <= in_px[COORD_BITS-1:0];
         mem_y[wr_idx] <= in_py[COORD_BITS-1:0];
      end
      if (cmd.v_read | cmd.e_read0 | cmd.e_read1) begin
         rx_ff <= mem_x[rd_addr];
         ry_ff <= mem_y[rd_addr];
      end
   end
   assign rd_addr = cmd.e_read1 ? rd_j : rd_k;

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         px_ff <= in_px[COORD_BITS-1:0];
         py_ff <= in_py[COORD_BITS-1:0];
         qx_ff <= in_qx[COORD_BITS-1:0];
         qy_ff <= in_qy[COORD_BITS-1:0];
      end
      if (cmd.e_read1) begin
         x0_ff <= rx_ff;
         y0_ff <= ry_ff;
      end
      if (reset) second_ff <= 1'b0;
      else if (cmd.len_start) second_ff <= 1'b0;
      else if (cmd.v_start) second_ff <= 1'b1;
      if (root_done_a && !cmd.len_start && !cmd.v_start) begin
         if (!second_ff) len_ff <= root_a;
         else d1_ff <= root_a;
      end
   end

   // length: P-Q on unit a; vertex: V-P on a, V-Q on b
   always_comb begin
      ax = cmd.len_start ? (px_ff - qx_ff) : (rx_ff - px_ff);
      ay = cmd.len_start ? (py_ff - qy_ff) : (ry_ff - py_ff);
      bx = rx_ff - qx_ff;
      by = ry_ff - qy_ff;
      sq_a = SQ_BITS'(ax * ax) + SQ_BITS'(ay * ay);
      sq_b = SQ_BITS'(bx * bx) + SQ_BITS'(by * by);
   end

   spi_root u_root_a (.clock, .reset, .start(cmd.len_start | cmd.v_start),
      .radicand(sq_a), .done(root_done_a), .root(root_a));
   spi_root u_root_b (.clock, .reset, .start(cmd.v_start),
      .radicand(sq_b), .done(root_done_b), .root(root_b));

   always_comb begin
      sum = {1'b0, d1_ff} + {1'b0, root_b};
      lim_hi = {1'b0, len_ff} + (ROOT_BITS+1)'(eps);
      sum_eps = sum + (ROOT_BITS+1)'(eps);
   end

   // edge: x0/y0 = V[k], rx/ry = V[j]
   always_comb begin
      lx = qx_ff - px_ff;
      ly = qy_ff - py_ff;
      ex = rx_ff - x0_ff;
      ey = ry_ff - y0_ff;
      wx = x0_ff - px_ff;
      wy = y0_ff - py_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.e_mul) begin
         m0_ff <= ex * ly;
         m1_ff <= ey * lx;
         m2_ff <= wx * ey;
         m3_ff <= wy * ex;
         m4_ff <= lx * wy;
         m5_ff <= ly * wx;
      end
      if (cmd.e_sum) begin
         den_ff <= m0_ff - m1_ff;
         na_ff <= m3_ff - m2_ff;
         nb_ff <= m4_ff - m5_ff;
      end
   end

   always_comb begin
      if (den_ff > 0) begin
         in_a = na_ff > 0 && na_ff < den_ff;
         in_b = nb_ff > 0 && nb_ff < den_ff;
      end else begin
         in_a = na_ff < 0 && na_ff > den_ff;
         in_b = nb_ff < 0 && nb_ff > den_ff;
      end
   end

   assign status.root_done = root_done_a & root_done_b;
   assign status.v_on_seg = d1_ff < len_ff && root_b < len_ff && sum < lim_hi
                            && sum_eps > {1'b0, len_ff};
   assign status.e_cross = den_ff != 0 && in_a && in_b;
endmodule
`default_nettype wire

// ===== sv/spi_ctrl.sv =====
// controller: sequences writes, length root, vertex tests and edge tests
`default_nettype none
module spi_ctrl
   import spi_pkg::*;
#(
   parameter int IDX_BITS = 4,
   parameter int CNT_BITS = 5
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 action,
   input  wire logic [CNT_BITS-1:0]  count,
   input  wire status_type           status,
   input  wire logic                 out_busy,
   output cmd_type                   cmd,
   output logic [IDX_BITS-1:0]       rd_k,
   output logic [IDX_BITS-1:0]       rd_j,
   output logic                      ready,
   output logic                      done,
   output logic [1:0]                kind
);
   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] k_ff, k_in;
   logic [1:0] kind_ff, kind_in;
   logic [CNT_BITS-1:0] k_next;

   assign k_next = k_ff + 1'b1;
   assign rd_k = k_ff[IDX_BITS-1:0];
   assign rd_j = (k_next == count) ? '0 : k_next[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         kind_ff <= KIND_NONE;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         kind_ff <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      kind_in = kind_ff;
      cmd = '0;
      ready = 1'b0;
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               if (action == ACT_WRITE) cmd.write_vertex = 1'b1;
               else begin
                  cmd.load_query = 1'b1;
                  kind_in = KIND_NONE;
                  k_in = '0;
                  state_in = ST_LEN_START;
               end
            end
         end
         ST_LEN_START: begin
            cmd.len_start = 1'b1;
            state_in = ST_LEN_WAIT;
         end
         ST_LEN_WAIT: if (status.root_done) begin
            state_in = (count == '0) ? ST_DONE : ST_V_READ;
         end
         ST_V_READ: begin
            cmd.v_read = 1'b1;
            state_in = ST_V_START;
         end
         ST_V_START: begin
            cmd.v_start = 1'b1;
            state_in = ST_V_WAIT;
         end
         ST_V_WAIT: if (status.root_done) state_in = ST_V_CHECK;
         ST_V_CHECK: begin
            if (status.v_on_seg) begin
               kind_in = KIND_VERTEX;
               state_in = ST_DONE;
            end else if (k_next == count) begin
               k_in = '0;
               state_in = ST_E_READ0;
            end else begin
               k_in = k_next;
               state_in = ST_V_READ;
            end
         end
         ST_E_READ0: begin
            cmd.e_read0 = 1'b1;
            state_in = ST_E_READ1;
         end
         ST_E_READ1: begin
            cmd.e_read1 = 1'b1;
            state_in = ST_E_MUL;
         end
         ST_E_MUL: begin
            cmd.e_mul = 1'b1;
            state_in = ST_E_SUM;
         end
         ST_E_SUM: begin
            cmd.e_sum = 1'b1;
            state_in = ST_E_CHECK;
         end
         ST_E_CHECK: begin
            if (status.e_cross) begin
               kind_in = KIND_EDGE;
               state_in = ST_DONE;
            end else if (k_next == count) state_in = ST_DONE;
            else begin
               k_in = k_next;
               state_in = ST_E_READ0;
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
   assign kind = kind_ff;

`ifndef SYNTHESIS
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_V_CHECK || state_ff == ST_E_CHECK) |-> k_ff < count)
      else $error("vertex counter out of range");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ST_IDLE)
      else $error("done without return to idle");
   a_edge_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E_READ0) |-> kind_ff == KIND_NONE)
      else $error("edge test after a hit");
`endif
endmodule
`default_nettype wire

// ===== sv/segment_polygon_intersect_unit.sv =====
// top level: segment against polygon intersection test with vertex store
// a write is stored on acceptance and gives no result; a query runs the length root,
// then a vertex test for each of the n vertices, then an edge test for each, n the vertex count,
// ending early on a hit; the result waits while the previous one is stalled at the output
// the two 25-step square roots of a vertex test run side by side
// throughput: one item at a time; a new item is taken only when idle
// reset: synchronous, active high; vertex_count 3, eps_tolerance 1, store not cleared
`default_nettype none
module segment_polygon_intersect_unit
   import spi_pkg::*;
#(
   parameter int MAX_VERTICES = 16
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [3:0]            req_vertex_index,
   input  wire logic signed [15:0]    req_px,
   input  wire logic signed [15:0]    req_py,
   input  wire logic signed [15:0]    req_qx,
   input  wire logic signed [15:0]    req_qy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [1:0]                 rsp_hit_kind,
   input  wire logic                  csr_write,
   input  wire logic [0:0]            csr_index,
   input  wire logic [15:0]           csr_wdata
);
   localparam int IDX_BITS = $clog2(MAX_VERTICES);
   localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

   // config registers
   logic [4:0] vcount_ff;
   logic [15:0] eps_ff;
   logic [CNT_BITS-1:0] count;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 5'd3;
         eps_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[4:0];
            CSR_EPS_TOLERANCE: eps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end
   // saturate the count at the store depth
   assign count = (32'(vcount_ff) > MAX_VERTICES) ? CNT_BITS'(MAX_VERTICES)
                                                  : CNT_BITS'(vcount_ff);

   cmd_type cmd;
   status_type status;
   logic [IDX_BITS-1:0] rd_k, rd_j, wr_idx;
   logic ready, done, accept, wr_ok;
   logic [1:0] kind;
   logic rsp_valid_ff;
   logic [1:0] kind_ff;

   assign accept = req_valid & ready;
   assign req_stall = ~ready;
   // writes to slots past the store depth are dropped
   assign wr_ok = 32'(req_vertex_index) < MAX_VERTICES;
   assign wr_idx = IDX_BITS'(req_vertex_index);

   cmd_type cmd_dp;
   always_comb begin
      cmd_dp = cmd;
      cmd_dp.write_vertex = cmd.write_vertex & wr_ok;
   end

   spi_ctrl #(.IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)) u_ctrl (
      .clock, .reset, .start(accept), .action(req_action), .count,
      .status, .out_busy(rsp_valid_ff & rsp_stall), .cmd, .rd_k, .rd_j,
      .ready, .done, .kind);

   spi_datapath #(.MAX_VERTICES(MAX_VERTICES), .IDX_BITS(IDX_BITS)) u_dp (
      .clock, .reset, .cmd(cmd_dp), .rd_k, .rd_j, .wr_idx, .eps(eps_ff),
      .in_px(req_px), .in_py(req_py), .in_qx(req_qx), .in_qy(req_qy), .status);

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (done) kind_ff <= kind;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit_kind = kind_ff;
   assign rsp_hit = kind_ff != KIND_NONE;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !done)
      else $error("result overwritten while stalled");
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_kind != 2'd3)
      else $error("illegal hit kind");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      $past(accept && req_action == ACT_QUERY) |-> req_stall)
      else $error("query accepted without going busy");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/segment_polygon_intersect_unit_test.sv =====
// testbench: random and directed checking of the segment against polygon unit
`default_nettype none
module segment_polygon_intersect_unit_test
   import spi_pkg::*;
();

   typedef struct {
      logic              action;
      logic [3:0]        slot;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
   } item_type;

   typedef struct {
      logic       hit;
      logic [1:0] kind;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = ACT_WRITE;
   logic [3:0]         req_vertex_index = '0;
   logic signed [15:0] req_px = '0;
   logic signed [15:0] req_py = '0;
   logic signed [15:0] req_qx = '0;
   logic signed [15:0] req_qy = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic [1:0]         rsp_hit_kind;
   logic               csr_write = 1'b0;
   logic [0:0]         csr_index = CSR_VERTEX_COUNT;
   logic [15:0]        csr_wdata = '0;

   segment_polygon_intersect_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_vertex_index(req_vertex_index), .req_px(req_px), .req_py(req_py),
      .req_qx(req_qx), .req_qy(req_qy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_hit_kind(rsp_hit_kind),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the block's polygon store and registers
   logic signed [15:0] poly_x[16];
   logic signed [15:0] poly_y[16];
   logic [4:0]         shadow_count = 5'd3;
   logic [15:0]        shadow_eps = 16'd1;

   item_type   pending_items[$];
   answer_type expected_answers[$];
   int      mismatches = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   bit      quiet = 0;      // no idling in the closing phase
   bit      hold_trigger = 0;
   bit      hold_done = 0;
   int      hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // floor of the square root, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // length with 8 fraction bits
   function automatic longint unsigned fixed_len(longint ax, longint ay, longint bx,
                                                 longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return int_sqrt(longint'(dx * dx + dy * dy) << 16);
   endfunction

   // num/den strictly inside (0,1), den nonzero
   function automatic bit strictly_inside(longint num, longint den);
      if (den > 0) return num > 0 && num < den;
      return num < 0 && num > den;
   endfunction

   function automatic logic [1:0] intersect_kind(item_type it);
      int n, j;
      logic [1:0] kind;
      longint unsigned seg, d1, d2, total;
      longint lx, ly, x0, y0, x1, y1, den, na, nb;
      kind = KIND_NONE;
      n = (shadow_count > 16) ? 16 : shadow_count;
      seg = fixed_len(it.px, it.py, it.qx, it.qy);
      // vertex lying on the segment takes precedence
      for (int k = 0; k < n && kind == KIND_NONE; k++) begin
         d1 = fixed_len(poly_x[k], poly_y[k], it.px, it.py);
         d2 = fixed_len(poly_x[k], poly_y[k], it.qx, it.qy);
         total = d1 + d2;
         if (d1 < seg && d2 < seg && total < seg + shadow_eps && total + shadow_eps > seg)
            kind = KIND_VERTEX;
      end
      lx = longint'(it.qx) - it.px;
      ly = longint'(it.qy) - it.py;
      // edge walk, last edge closes back to vertex 0
      for (int k = 0; k < n && kind == KIND_NONE; k++) begin
         j = (k + 1 == n) ? 0 : k + 1;
         x0 = poly_x[k];
         y0 = poly_y[k];
         x1 = poly_x[j];
         y1 = poly_y[j];
         den = (x1 - x0) * ly - (y1 - y0) * lx;
         if (den != 0) begin
            na = (x0 - it.px) * (y0 - y1) - (y0 - it.py) * (x0 - x1);
            nb = lx * (y0 - it.py) - ly * (x0 - it.px);
            if (strictly_inside(na, den) && strictly_inside(nb, den)) kind = KIND_EDGE;
         end
      end
      return kind;
   endfunction

   // driver: feeds queued items, takes the prediction on acceptance
   always @(posedge clock) begin
      item_type it;
      answer_type ans;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            it.action = req_action;
            it.slot = req_vertex_index;
            it.px = req_px;
            it.py = req_py;
            it.qx = req_qx;
            it.qy = req_qy;
            if (it.action == ACT_WRITE) begin
               poly_x[it.slot] = it.px;
               poly_y[it.slot] = it.py;
            end else begin
               ans.kind = intersect_kind(it);
               ans.hit = ans.kind != KIND_NONE;
               expected_answers = {expected_answers, ans};
            end
         end
         // a stalled item stays put
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_action <= it.action;
               req_vertex_index <= it.slot;
               req_px <= it.px;
               req_py <= it.py;
               req_qx <= it.qx;
               req_qy <= it.qy;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_trigger && !hold_done) begin
         hold_done <= 1;
         hold_left <= 3000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: checks each taken result, then picks the next stall
   always @(posedge clock) begin
      answer_type ans;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result hit=%0d kind=%0d", rsp_hit, rsp_hit_kind);
            end else begin
               ans = expected_answers.pop_front();
               if (rsp_hit !== ans.hit || rsp_hit_kind !== ans.kind) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected hit=%0d kind=%0d, got hit=%0d kind=%0d",
                              ans.hit, ans.kind, rsp_hit, rsp_hit_kind);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 6);
         end
      end
   end

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] any_coord();
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic push_item(logic act, logic [3:0] slot, longint px, longint py,
                            longint qx, longint qy);
      item_type it;
      it.action = act;
      it.slot = slot;
      it.px = clamp16(px);
      it.py = clamp16(py);
      it.qx = clamp16(qx);
      it.qy = clamp16(qy);
      pending_items = {pending_items, it};
   endtask

   // mostly segments through a stored vertex or random crossings, some noise
   task automatic push_random(int count, int used);
      int r, k, ox, oy;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            push_item(ACT_WRITE, 4'($urandom_range(0, 15)), any_coord(), any_coord(),
                      any_coord(), any_coord());
         end else if (r < 50) begin
            k = $urandom_range(0, (used > 0) ? used - 1 : 0);
            ox = $urandom_range(0, 3000) - 1500;
            oy = $urandom_range(0, 3000) - 1500;
            push_item(ACT_QUERY, 4'($urandom), longint'(poly_x[k]) - ox,
                      longint'(poly_y[k]) - oy,
                      longint'(poly_x[k]) + ox + $urandom_range(0, 2) - 1,
                      longint'(poly_y[k]) + oy);
         end else if (r < 85) begin
            push_item(ACT_QUERY, 4'($urandom), any_coord(), any_coord(),
                      any_coord(), any_coord());
         end else begin
            ox = $urandom_range(0, 64) - 32;
            oy = $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 3) == 0) push_item(ACT_QUERY, 0, ox, oy, ox, oy);
            else push_item(ACT_QUERY, 0, ox, oy, $urandom_range(0, 64) - 32,
                           $urandom_range(0, 64) - 32);
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      // writes leave no result; let the last one settle
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_VERTEX_COUNT) shadow_count = value[4:0];
      else shadow_eps = value;
   endtask

   initial begin
      logic [15:0] counts[8];
      logic [15:0] tols[8];
      int used;
      counts = '{16'd16, 16'd3, 16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h0000, 16'd16};
      tols = '{16'd1, 16'd0, 16'd65535, 16'd256, 16'd1, 16'd0, 16'd4096, 16'd512};
      counts[6] = 16'($urandom);
      tols[4] = 16'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill every slot first so no query reads an unwritten vertex
      push_item(ACT_WRITE, 0, -32768, -32768, 32767, 32767);
      push_item(ACT_WRITE, 1, 32767, -32768, -1, -1);
      push_item(ACT_WRITE, 2, 0, 32767, 0, 0);
      for (int s = 3; s < 16; s++)
         push_item(ACT_WRITE, 4'(s), any_coord(), any_coord(), any_coord(), any_coord());
      // degenerate segment on a vertex
      push_item(ACT_QUERY, 0, 0, 32767, 0, 32767);
      // vertex on segment: through the top vertex
      push_item(ACT_QUERY, 0, -100, 32767, 100, 32767);
      // proper crossing of the triangle
      push_item(ACT_QUERY, 15, 0, -32768, 0, 32767);
      push_item(ACT_QUERY, 0, -32768, 0, 32767, 0);
      // extreme corners, one parallel to the bottom edge, and a short inner segment
      push_item(ACT_QUERY, 0, -32768, -32767, 32767, -32767);
      push_item(ACT_QUERY, 0, 32767, 32767, -32768, -32768);
      push_item(ACT_QUERY, 0, 5, 5, 6, 6);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_VERTEX_COUNT, counts[ph]);
         write_reg(CSR_EPS_TOLERANCE, tols[ph]);
         used = (shadow_count > 16) ? 16 : shadow_count;
         if (ph == 1) hold_trigger = 1;
         if (ph == 7) quiet = 1;
         push_random(70, used);
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
